@@ rtl/tcsq_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the threshold component size query block.
// Used by tcsq_ctrl, tcsq_dp and threshold_component_size_query.
package tcsq_pkg;

    localparam logic [1:0] OP_EDGE  = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_RUN   = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // signed width that holds any threshold and any zero-extended weight
    localparam int CW = 34;

    typedef struct packed {
        logic ld_edge;
        logic ld_qry;
        logic clr_tot;
        logic pas_init;
        logic pas_shift;
        logic qi_clr;
        logic qi_inc;
        logic ans_rd;
        logic ans_wr_init;
        logic ans_wr_mark;
        logic step_init;
        logic j_inc;
        logic node_wr_clr;
        logic sel_chk;
        logic thr_ld;
        logic e_inc;
        logic edge_rd;
        logic v_ld_a;
        logic v_ld_b;
        logic v_ld_q;
        logic v_ld_par;
        logic node_rd;
        logic cap_a;
        logic cap_b;
        logic uni1;
        logic uni2;
        logic qry_rd;
        logic cap_ok;
        logic ok_clr;
        logic mark;
        logic out_ld;
    } dp_cmd_t;

    typedef struct packed {
        logic qt_zero;
        logic et_zero;
        logic q_last;
        logic j_last;
        logic e_last;
        logic rank_last;
        logic edge_add;
        logic is_root;
        logic same_root;
        logic target_ok;
        logic ok;
        logic pas_last;
        logic out_done;
    } dp_stat_t;

endpackage

@@ rtl/tcsq_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module tcsq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/tcsq_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine: load handling, search passes, answer output.
// Depends on tcsq_pkg.
module tcsq_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_cmd,
    input  tcsq_pkg::dp_stat_t stat,
    output tcsq_pkg::dp_cmd_t  cmd
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_INIT, ST_CLR, ST_SEL_REQ, ST_SEL_CHK, ST_THR,
        ST_EDGE_REQ, ST_EDGE_CHK, ST_FA_REQ, ST_FA_CHK, ST_FB_REQ, ST_FB_CHK,
        ST_UNI1, ST_UNI2, ST_QRY_REQ, ST_QRY_CHK, ST_FQ_REQ, ST_FQ_CHK,
        ST_MARK, ST_OUT_REQ, ST_OUT_LD, ST_OUT_WAIT
    } state_t;

    state_t state_reg, state_next;
    state_t after_edge;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign after_edge = stat.e_last ? ST_QRY_REQ : ST_EDGE_REQ;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_cmd == tcsq_pkg::OP_EDGE) begin
                        cmd.ld_edge = 1'b1;
                    end else if (s_cmd == tcsq_pkg::OP_QUERY) begin
                        cmd.ld_qry = 1'b1;
                    end else if (s_cmd == tcsq_pkg::OP_RUN) begin
                        if (stat.qt_zero) begin
                            cmd.clr_tot = 1'b1;
                        end else begin
                            cmd.pas_init = 1'b1;
                            cmd.qi_clr   = 1'b1;
                            state_next   = ST_INIT;
                        end
                    end
                end
            end
            ST_INIT: begin
                cmd.ans_wr_init = 1'b1;
                cmd.qi_inc      = 1'b1;
                if (stat.q_last) begin
                    cmd.step_init = 1'b1;
                    state_next    = ST_CLR;
                end
            end
            ST_CLR: begin
                cmd.node_wr_clr = 1'b1;
                cmd.j_inc       = 1'b1;
                if (stat.j_last) begin
                    cmd.qi_clr = 1'b1;
                    state_next = ST_SEL_REQ;
                end
            end
            ST_SEL_REQ: begin
                cmd.ans_rd = 1'b1;
                state_next = ST_SEL_CHK;
            end
            ST_SEL_CHK: begin
                cmd.sel_chk = 1'b1;
                cmd.qi_inc  = 1'b1;
                state_next  = stat.q_last ? ST_THR : ST_SEL_REQ;
            end
            ST_THR: begin
                cmd.thr_ld = 1'b1;
                state_next = stat.et_zero ? ST_QRY_REQ : ST_EDGE_REQ;
            end
            ST_EDGE_REQ: begin
                cmd.edge_rd = 1'b1;
                state_next  = ST_EDGE_CHK;
            end
            ST_EDGE_CHK: begin
                if (stat.edge_add) begin
                    cmd.v_ld_a = 1'b1;
                    state_next = ST_FA_REQ;
                end else begin
                    cmd.e_inc  = 1'b1;
                    state_next = after_edge;
                end
            end
            ST_FA_REQ: begin
                cmd.node_rd = 1'b1;
                state_next  = ST_FA_CHK;
            end
            ST_FA_CHK: begin
                if (stat.is_root) begin
                    cmd.cap_a  = 1'b1;
                    cmd.v_ld_b = 1'b1;
                    state_next = ST_FB_REQ;
                end else begin
                    cmd.v_ld_par = 1'b1;
                    state_next   = ST_FA_REQ;
                end
            end
            ST_FB_REQ: begin
                cmd.node_rd = 1'b1;
                state_next  = ST_FB_CHK;
            end
            ST_FB_CHK: begin
                if (stat.is_root) begin
                    cmd.cap_b  = 1'b1;
                    state_next = ST_UNI1;
                end else begin
                    cmd.v_ld_par = 1'b1;
                    state_next   = ST_FB_REQ;
                end
            end
            ST_UNI1: begin
                if (stat.same_root) begin
                    cmd.e_inc  = 1'b1;
                    state_next = after_edge;
                end else begin
                    cmd.uni1   = 1'b1;
                    state_next = ST_UNI2;
                end
            end
            ST_UNI2: begin
                cmd.uni2   = 1'b1;
                cmd.e_inc  = 1'b1;
                state_next = after_edge;
            end
            ST_QRY_REQ: begin
                cmd.qry_rd = 1'b1;
                state_next = ST_QRY_CHK;
            end
            ST_QRY_CHK: begin
                if (stat.target_ok) begin
                    cmd.v_ld_q = 1'b1;
                    state_next = ST_FQ_REQ;
                end else begin
                    cmd.ok_clr = 1'b1;
                    state_next = ST_MARK;
                end
            end
            ST_FQ_REQ: begin
                cmd.node_rd = 1'b1;
                state_next  = ST_FQ_CHK;
            end
            ST_FQ_CHK: begin
                if (stat.is_root) begin
                    cmd.cap_ok = 1'b1;
                    state_next = ST_MARK;
                end else begin
                    cmd.v_ld_par = 1'b1;
                    state_next   = ST_FQ_REQ;
                end
            end
            ST_MARK: begin
                cmd.mark        = 1'b1;
                cmd.ans_wr_mark = stat.ok;
                cmd.qi_clr      = 1'b1;
                if (!stat.rank_last) begin
                    state_next = ST_SEL_REQ;
                end else if (stat.pas_last) begin
                    state_next = ST_OUT_REQ;
                end else begin
                    cmd.pas_shift = 1'b1;
                    cmd.step_init = 1'b1;
                    state_next    = ST_CLR;
                end
            end
            ST_OUT_REQ: begin
                cmd.ans_rd = 1'b1;
                state_next = ST_OUT_LD;
            end
            ST_OUT_LD: begin
                cmd.out_ld = 1'b1;
                state_next = ST_OUT_WAIT;
            end
            ST_OUT_WAIT: begin
                if (stat.out_done) begin
                    if (stat.q_last) begin
                        cmd.clr_tot = 1'b1;
                        state_next  = ST_IDLE;
                    end else begin
                        cmd.qi_inc = 1'b1;
                        state_next = ST_OUT_REQ;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/tcsq_dp.sv @@
`timescale 1ns / 1ps
// Datapath: edge, query, answer and union-find memories, counters, compares.
// Depends on tcsq_pkg and tcsq_ram.
module tcsq_dp #(
    parameter int MAX_NODES   = 1024,
    parameter int MAX_EDGES   = 1024,
    parameter int MAX_QUERIES = 64,
    parameter int SEARCH_BITS = 30
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [10:0]               cfg_wr_data,
    input  logic [9:0]                s_end_a,
    input  logic [9:0]                s_end_b,
    input  logic [30:0]               s_weight,
    input  logic [9:0]                s_query_node,
    input  logic [10:0]               s_min_size,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [30:0]        m_answer,
    output logic [5:0]                m_query_number,
    output logic                      m_last,
    input  tcsq_pkg::dp_cmd_t         cmd,
    output tcsq_pkg::dp_stat_t        stat
);

    localparam int NAW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int SZW = $clog2(MAX_NODES + 1);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ETW = $clog2(MAX_EDGES + 1);
    localparam int QAW = (MAX_QUERIES > 1) ? $clog2(MAX_QUERIES) : 1;
    localparam int QTW = $clog2(MAX_QUERIES + 1);
    localparam int AW  = SEARCH_BITS + 1;
    localparam int CW  = tcsq_pkg::CW;
    localparam int EDW = 51;
    localparam int QDW = 21;
    localparam int NDW = SZW + NAW;

    logic [10:0]           node_count_reg;
    logic [ETW-1:0]        et_reg;
    logic [QTW-1:0]        qt_reg;
    logic [EAW-1:0]        e_reg;
    logic [QAW-1:0]        qi_reg, rank_reg, sel_reg;
    logic [NAW-1:0]        j_reg, v_reg, ra_reg, rb_reg;
    logic [SZW-1:0]        sa_reg, sb_reg;
    logic signed [AW-1:0]  best_reg;
    logic signed [CW-1:0]  thr_reg, prev_reg, pas_reg;
    logic                  first_reg, found_reg, ok_reg;
    logic [MAX_QUERIES-1:0] done_reg;
    logic                  m_valid_reg, m_last_reg;
    logic [30:0]           m_answer_reg;
    logic [5:0]            m_qn_reg;

    logic                  edge_we, qry_we, ans_we, node_we;
    logic [EDW-1:0]        edge_rdata;
    logic [QDW-1:0]        qry_rdata;
    logic [AW-1:0]         ans_rdata, ans_wdata;
    logic [QAW-1:0]        ans_waddr;
    logic [NDW-1:0]        node_rdata, node_wdata;
    logic [NAW-1:0]        node_waddr;

    logic [9:0]            ed_a, ed_b, q_target;
    logic [30:0]           ed_w;
    logic [10:0]           q_need;
    logic [NAW-1:0]        nd_par;
    logic [SZW-1:0]        nd_size;
    logic signed [AW-1:0]  ans_s;
    logic signed [CW-1:0]  ans_ext, w_ext, thr_next;
    logic                  a_small;
    logic [NAW-1:0]        child, root;
    logic [SZW-1:0]        sum_size;

    assign ed_a     = edge_rdata[9:0];
    assign ed_b     = edge_rdata[19:10];
    assign ed_w     = edge_rdata[50:20];
    assign q_target = qry_rdata[9:0];
    assign q_need   = qry_rdata[20:10];
    assign nd_par   = node_rdata[NAW-1:0];
    assign nd_size  = node_rdata[NDW-1:NAW];
    assign ans_s    = $signed(ans_rdata);
    assign ans_ext  = CW'(ans_s);
    assign w_ext    = $signed({3'b000, ed_w});
    assign thr_next = CW'(best_reg) + pas_reg;
    assign a_small  = (sa_reg < sb_reg);
    assign child    = a_small ? ra_reg : rb_reg;
    assign root     = a_small ? rb_reg : ra_reg;
    assign sum_size = sa_reg + sb_reg;

    assign edge_we = cmd.ld_edge && (32'(et_reg) < 32'(MAX_EDGES));
    assign qry_we  = cmd.ld_qry && (32'(qt_reg) < 32'(MAX_QUERIES));

    assign ans_we    = cmd.ans_wr_init || cmd.ans_wr_mark;
    assign ans_waddr = cmd.ans_wr_init ? qi_reg : sel_reg;
    assign ans_wdata = cmd.ans_wr_init ? '1 : thr_reg[AW-1:0];

    always_comb begin
        node_we    = cmd.node_wr_clr || cmd.uni1 || cmd.uni2;
        node_waddr = j_reg;
        node_wdata = {SZW'(1), j_reg};
        if (cmd.uni1) begin
            node_waddr = child;
            node_wdata = {(a_small ? sa_reg : sb_reg), root};
        end else if (cmd.uni2) begin
            node_waddr = root;
            node_wdata = {sum_size, root};
        end
    end

    tcsq_ram #(.WIDTH(EDW), .DEPTH(MAX_EDGES)) u_edge_ram (
        .aclk  (aclk),
        .we    (edge_we),
        .waddr (EAW'(et_reg)),
        .wdata ({s_weight, s_end_b, s_end_a}),
        .re    (cmd.edge_rd),
        .raddr (e_reg),
        .rdata (edge_rdata)
    );

    tcsq_ram #(.WIDTH(QDW), .DEPTH(MAX_QUERIES)) u_qry_ram (
        .aclk  (aclk),
        .we    (qry_we),
        .waddr (QAW'(qt_reg)),
        .wdata ({s_min_size, s_query_node}),
        .re    (cmd.qry_rd),
        .raddr (sel_reg),
        .rdata (qry_rdata)
    );

    tcsq_ram #(.WIDTH(AW), .DEPTH(MAX_QUERIES)) u_ans_ram (
        .aclk  (aclk),
        .we    (ans_we),
        .waddr (ans_waddr),
        .wdata (ans_wdata),
        .re    (cmd.ans_rd),
        .raddr (qi_reg),
        .rdata (ans_rdata)
    );

    tcsq_ram #(.WIDTH(NDW), .DEPTH(MAX_NODES)) u_node_ram (
        .aclk  (aclk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .re    (cmd.node_rd),
        .raddr (v_reg),
        .rdata (node_rdata)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= 11'd1;
            et_reg         <= '0;
            qt_reg         <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                node_count_reg <= cfg_wr_data;
            end
            if (cmd.clr_tot) begin
                et_reg <= '0;
                qt_reg <= '0;
            end else begin
                if (edge_we) begin
                    et_reg <= et_reg + ETW'(1);
                end
                if (qry_we) begin
                    qt_reg <= qt_reg + QTW'(1);
                end
            end
            if (cmd.out_ld) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // search registers
    always_ff @(posedge aclk) begin
        if (cmd.pas_init) begin
            pas_reg <= CW'(1) <<< (SEARCH_BITS - 1);
        end else if (cmd.pas_shift) begin
            pas_reg <= pas_reg >>> 1;
        end
        if (cmd.qi_clr) begin
            qi_reg    <= '0;
            found_reg <= 1'b0;
        end else if (cmd.qi_inc) begin
            qi_reg <= qi_reg + QAW'(1);
        end
        if (cmd.step_init) begin
            j_reg     <= '0;
            rank_reg  <= '0;
            first_reg <= 1'b1;
            done_reg  <= '0;
        end else begin
            if (cmd.j_inc) begin
                j_reg <= j_reg + NAW'(1);
            end
            if (cmd.mark) begin
                rank_reg          <= rank_reg + QAW'(1);
                first_reg         <= 1'b0;
                prev_reg          <= thr_reg;
                done_reg[sel_reg] <= 1'b1;
            end
        end
        if (cmd.sel_chk && !done_reg[qi_reg] && (!found_reg || ans_s > best_reg)) begin
            best_reg  <= ans_s;
            sel_reg   <= qi_reg;
            found_reg <= 1'b1;
        end
        if (cmd.thr_ld) begin
            thr_reg <= thr_next;
            e_reg   <= '0;
        end else if (cmd.e_inc) begin
            e_reg <= e_reg + EAW'(1);
        end
        if (cmd.v_ld_a) begin
            v_reg <= NAW'(ed_a);
        end else if (cmd.v_ld_b) begin
            v_reg <= NAW'(ed_b);
        end else if (cmd.v_ld_q) begin
            v_reg <= NAW'(q_target);
        end else if (cmd.v_ld_par) begin
            v_reg <= nd_par;
        end
        if (cmd.cap_a) begin
            ra_reg <= v_reg;
            sa_reg <= nd_size;
        end
        if (cmd.cap_b) begin
            rb_reg <= v_reg;
            sb_reg <= nd_size;
        end
        if (cmd.ok_clr) begin
            ok_reg <= 1'b0;
        end else if (cmd.cap_ok) begin
            ok_reg <= (32'(nd_size) >= 32'(q_need));
        end
        if (cmd.out_ld) begin
            m_answer_reg <= ans_ext[30:0];
            m_qn_reg     <= 6'(qi_reg);
            m_last_reg   <= stat.q_last;
        end
    end

    assign stat.qt_zero   = (qt_reg == '0);
    assign stat.et_zero   = (et_reg == '0);
    assign stat.q_last    = (qi_reg == QAW'(qt_reg - QTW'(1)));
    assign stat.j_last    = (32'(j_reg) == 32'(MAX_NODES - 1));
    assign stat.e_last    = (e_reg == EAW'(et_reg - ETW'(1)));
    assign stat.rank_last = (rank_reg == QAW'(qt_reg - QTW'(1)));
    assign stat.edge_add  = (w_ext >= thr_reg) && (first_reg || (w_ext < prev_reg))
                            && (11'(ed_a) < node_count_reg) && (32'(ed_a) < 32'(MAX_NODES))
                            && (11'(ed_b) < node_count_reg) && (32'(ed_b) < 32'(MAX_NODES));
    assign stat.is_root   = (nd_par == v_reg);
    assign stat.same_root = (ra_reg == rb_reg);
    assign stat.target_ok = (11'(q_target) < node_count_reg)
                            && (32'(q_target) < 32'(MAX_NODES));
    assign stat.ok        = ok_reg;
    assign stat.pas_last  = (pas_reg == CW'(1));
    assign stat.out_done  = m_valid_reg && m_ready;

    assign m_valid        = m_valid_reg;
    assign m_answer       = $signed(m_answer_reg);
    assign m_query_number = m_qn_reg;
    assign m_last         = m_last_reg;

`ifndef SYNTHESIS
    a_edge_total: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(et_reg) <= 32'(MAX_EDGES)) else $error("edge total beyond capacity");
    a_query_total: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(qt_reg) <= 32'(MAX_QUERIES)) else $error("query total beyond capacity");
    a_union_roots: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.uni1 |-> (ra_reg != rb_reg)) else $error("union of a set with itself");
    a_mark_sel: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mark |-> (found_reg && !done_reg[sel_reg])) else $error("mark without selection");
`endif

endmodule

@@ rtl/threshold_component_size_query.sv @@
`timescale 1ns / 1ps
// Top level of the threshold component size query block.
// Depends on tcsq_pkg, tcsq_ctrl, tcsq_dp and tcsq_ram.
//
// Input channel (s_valid/s_ready): s_cmd selects edge load, query load or run.
// Loads are taken one per cycle while idle; loads beyond capacity are dropped.
// A run with queries starts a parallel binary search of SEARCH_BITS passes; the
// input stalls until the last answer has left; with none, it only clears totals.
// Per pass: the union-find memory is cleared entry by entry, then for each query
// in turn one is picked from the queries loaded, each stored edge is scanned with
// a find per endpoint and a union where roots differ, and the query is checked.
// The edge scan and the one-read-port union-find memory set the run length.
// Result channel (m_valid/m_ready): one transaction per query in load order,
// m_last on the final one; the block holds the result until accepted.
// Configuration: cfg_wr_en writes node_count; the user writes only while idle (unchecked).
// Reset (aresetn, synchronous, active low): totals cleared, node_count = 1.
module threshold_component_size_query #(
    parameter int MAX_NODES   = 1024,
    parameter int MAX_EDGES   = 1024,
    parameter int MAX_QUERIES = 64,
    parameter int SEARCH_BITS = 30
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [10:0]        cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_cmd,
    input  logic [9:0]         s_end_a,
    input  logic [9:0]         s_end_b,
    input  logic [30:0]        s_weight,
    input  logic [9:0]         s_query_node,
    input  logic [10:0]        s_min_size,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [30:0] m_answer,
    output logic [5:0]         m_query_number,
    output logic               m_last
);

    tcsq_pkg::dp_cmd_t  cmd;
    tcsq_pkg::dp_stat_t stat;

    tcsq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_cmd   (s_cmd),
        .stat    (stat),
        .cmd     (cmd)
    );

    tcsq_dp #(
        .MAX_NODES   (MAX_NODES),
        .MAX_EDGES   (MAX_EDGES),
        .MAX_QUERIES (MAX_QUERIES),
        .SEARCH_BITS (SEARCH_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_end_a        (s_end_a),
        .s_end_b        (s_end_b),
        .s_weight       (s_weight),
        .s_query_node   (s_query_node),
        .s_min_size     (s_min_size),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_answer       (m_answer),
        .m_query_number (m_query_number),
        .m_last         (m_last),
        .cmd            (cmd),
        .stat           (stat)
    );

endmodule
